@@ rtl/fq15s_pkg.sv @@
// Package for the scaled Q1.15 FIR filter: item and result structs,
// function codes, the output gain and the saturating helper.
// No dependencies.
`default_nettype none

package fq15s_pkg;

  // Function codes carried in the func field of an input item.
  localparam logic [1:0] FUNC_FILTER = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  // The remaining code selects nothing and produces no result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Output gain of 0.3 in Q1.15.
  localparam logic signed [15:0] GAIN_Q15 = 16'sd9830;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] sample;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic               last_in_block;
  } in_t;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic               last_out;
  } out_t;

  // Per-tap control that travels with the operands into the MAC pipeline.
  typedef struct packed {
    logic valid;  // operands present this cycle
    logic first;  // first tap of a sample, restarts the accumulator
    logic last;   // final tap of a sample
    logic en;     // accumulate the term; low when no tap is active
  } mac_ctrl_t;

  // Clamp a 32-bit signed value to the Q1.15 range.
  function automatic logic signed [15:0] sat_q15(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sd32767;
    end else if (v < -32'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fir_filter_q15_scaled_top.sv @@
// Top level of the scaled Q1.15 FIR filter: delay line and coefficient
// memories, the tap sequencer and the output register.
// Depends on fq15s_pkg and fq15s_mac.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i/in_ready_o   in_data_i   (fq15s_pkg::in_t)
//   out       output     out_valid_o/out_ready_i out_data_o  (fq15s_pkg::out_t)
//   cfg       input      cfg_we_i                cfg_data_i  (num_taps, 7 bits)
//
// The sequencer walks the active taps of an accepted sample in order, and
// the block is not ready again until the result has left the accumulator.
// Each memory has a single read port: one tap is read per cycle.
// Load and clear transfers finish in the cycle they are accepted.
// Reset clears all control state and marks every memory entry as zero.
// A sample is accepted while an earlier result still waits on the output;
// its result then waits in the accumulator until the output is free.
`default_nettype none

module fir_filter_q15_scaled_top #(
  parameter int MAX_TAP_COUNT = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fq15s_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fq15s_pkg::out_t      out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [6:0]      cfg_data_i
);

  localparam int AW = (MAX_TAP_COUNT > 1) ? $clog2(MAX_TAP_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_WAIT
  } state_e;

  // Configuration register.
  logic [6:0] num_taps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= 7'd64;
    end else if (cfg_we_i) begin
      num_taps_q <= cfg_data_i;
    end
  end

  // Active tap count, limited to the memory depth. The sequencer always
  // walks at least one tap, because the new sample is written to position
  // zero even when no tap is active.
  logic [31:0]   taps_eff;
  logic [AW-1:0] last_idx_d;

  assign taps_eff   = (32'(num_taps_q) > 32'(MAX_TAP_COUNT)) ? 32'(MAX_TAP_COUNT)
                                                             : 32'(num_taps_q);
  assign last_idx_d = (taps_eff == 32'd0) ? '0 : AW'(taps_eff - 32'd1);

  // Sequencer state.
  state_e             state_q;
  logic [AW-1:0]      rd_idx_q, last_idx_q, rsp_idx_q;
  logic               rsp_valid_q, rsp_last_q;
  logic               en_q, last_in_q;
  logic signed [15:0] carry_q;
  logic               out_valid_q;
  fq15s_pkg::out_t    out_q;

  // Memories and their per-entry valid bits; a clear drops the valid bits.
  logic signed [15:0]        delay_mem [MAX_TAP_COUNT];
  logic signed [15:0]        coef_mem  [MAX_TAP_COUNT];
  logic [MAX_TAP_COUNT-1:0]  dvalid_q, cvalid_q;
  logic signed [15:0]        d_rdata_q, c_rdata_q;
  logic                      dv_rd_q, cv_rd_q;

  logic               in_xfer, out_free, load_ok, out_load;
  logic [AW-1:0]      load_addr;
  logic               res_valid;
  logic signed [15:0] res;
  fq15s_pkg::mac_ctrl_t mac_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_ok    = 32'(in_data_i.coef_index) < 32'(MAX_TAP_COUNT);
  assign load_addr  = AW'(in_data_i.coef_index);

  // The finished sum moves to the output register as soon as it is free,
  // either straight from the MAC or after waiting in the accumulator.
  assign out_load   = out_free &&
                      (((state_q == S_DRAIN) && res_valid) || (state_q == S_WAIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      last_idx_q  <= '0;
      rsp_idx_q   <= '0;
      rsp_valid_q <= 1'b0;
      rsp_last_q  <= 1'b0;
      en_q        <= 1'b0;
      last_in_q   <= 1'b0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      dvalid_q    <= '0;
      cvalid_q    <= '0;
    end else begin
      rsp_valid_q <= (state_q == S_RUN);
      rsp_idx_q   <= rd_idx_q;
      rsp_last_q  <= (rd_idx_q == last_idx_q);

      if (out_load) begin
        out_valid_q    <= 1'b1;
        out_q.filtered <= res;
        out_q.last_out <= last_in_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Each returning tap writes the value carried from the tap before it
      // and takes the old contents along to the next position.
      if (rsp_valid_q) begin
        dvalid_q[rsp_idx_q] <= 1'b1;
        carry_q             <= dv_rd_q ? d_rdata_q : 16'sd0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_data_i.func)
              fq15s_pkg::FUNC_FILTER: begin
                carry_q    <= in_data_i.sample;
                last_in_q  <= in_data_i.last_in_block;
                en_q       <= (taps_eff != 32'd0);
                last_idx_q <= last_idx_d;
                rd_idx_q   <= '0;
                state_q    <= S_RUN;
              end
              fq15s_pkg::FUNC_LOAD: begin
                if (load_ok) begin
                  cvalid_q[load_addr] <= 1'b1;
                end
              end
              fq15s_pkg::FUNC_CLEAR: begin
                dvalid_q <= '0;
                cvalid_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          rd_idx_q <= rd_idx_q + AW'(1);
          if (rd_idx_q == last_idx_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res_valid) begin
            state_q <= out_free ? S_IDLE : S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Delay line: read one tap ahead of the write, so the two never collide.
  always_ff @(posedge clk_i) begin
    if (rsp_valid_q) begin
      delay_mem[rsp_idx_q] <= carry_q;
    end
    if (state_q == S_RUN) begin
      d_rdata_q <= delay_mem[rd_idx_q];
      dv_rd_q   <= dvalid_q[rd_idx_q];
    end
  end

  // Coefficient table: written only by load transfers while idle.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (in_data_i.func == fq15s_pkg::FUNC_LOAD) && load_ok) begin
      coef_mem[load_addr] <= in_data_i.coef_value;
    end
    if (state_q == S_RUN) begin
      c_rdata_q <= coef_mem[rd_idx_q];
      cv_rd_q   <= cvalid_q[rd_idx_q];
    end
  end

  assign mac_ctrl.valid = rsp_valid_q;
  assign mac_ctrl.first = (rsp_idx_q == '0);
  assign mac_ctrl.last  = rsp_last_q;
  assign mac_ctrl.en    = en_q;

  fq15s_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .coef_i      (cv_rd_q ? c_rdata_q : 16'sd0),
    .data_i      (carry_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The accumulated result only comes back while the sequencer waits for it.
  a_res_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (state_q == S_DRAIN))
    else $error("MAC result arrived outside the drain state");

  // A returning tap never lies beyond the last active tap.
  a_rsp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_idx_q <= last_idx_q))
    else $error("delay write beyond the active taps");

  // Read and write of the delay line never address the same entry.
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && rsp_valid_q) |-> (rd_idx_q != rsp_idx_q))
    else $error("delay line read and write collide");

  // No tap is in flight once the block is ready for the next transfer.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rsp_valid_q)
    else $error("tap still in flight while idle");

endmodule

`default_nettype wire

@@ rtl/fq15s_mac.sv @@
// Three-stage saturating multiply-accumulate for the scaled Q1.15 FIR.
// Uses fq15s_pkg for the control struct, the gain and sat_q15.
`default_nettype none

module fq15s_mac (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fq15s_pkg::mac_ctrl_t  ctrl_i,
  input  wire logic signed [15:0]    coef_i,
  input  wire logic signed [15:0]    data_i,
  output logic                       res_valid_o,
  output logic signed [15:0]         res_o
);

  fq15s_pkg::mac_ctrl_t ctrl1_q, ctrl2_q;
  logic                 done_q;
  logic signed [31:0]   p1_q, p2_q;
  logic signed [15:0]   acc_q;

  logic signed [31:0]   p1_d, p2_d, sum;
  logic signed [15:0]   q1, q2, base, addend;

  // Stage 1: coefficient times delayed sample.
  assign p1_d = coef_i * data_i;

  // Stage 2: Q1.15 product, truncated and saturated, then times the gain.
  assign q1   = fq15s_pkg::sat_q15(p1_q >>> 15);
  assign p2_d = q1 * fq15s_pkg::GAIN_Q15;

  // Stage 3: scaled term into the saturating accumulator.
  assign q2     = fq15s_pkg::sat_q15(p2_q >>> 15);
  assign base   = ctrl2_q.first ? 16'sd0 : acc_q;
  assign addend = ctrl2_q.en ? q2 : 16'sd0;
  assign sum    = base + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      done_q  <= ctrl2_q.valid && ctrl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    if (ctrl2_q.valid) begin
      acc_q <= fq15s_pkg::sat_q15(sum);
    end
  end

  assign res_valid_o = done_q;
  assign res_o       = acc_q;

endmodule

`default_nettype wire
